### hdl/assert_macros.svh
// assert_macros.svh: assertion macros shared by the transform engine modules
// depends on: clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every clock, quiet while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression that must never hold on a clock edge
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

### hdl/m4vt_pkg.sv
// m4vt_pkg: types, op codes and fixed-point constants of the matrix transform engine
// depends on: nothing
`timescale 1ns / 1ps

package m4vt_pkg;

    // fixed-point format and matrix size
    localparam int FRAC_BITS = 16;
    localparam int DIM       = 4;
    localparam int MAT_N     = 4;
    localparam int HALF_N    = MAT_N / 2;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;

    // op codes
    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_XFORM     = 2'd1;
    localparam logic [1:0] OP_IDENT     = 2'd2;
    localparam logic [1:0] OP_TRANSPOSE = 2'd3;

    // constants
    localparam logic [DATA_W-1:0] ONE_Q   = DATA_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] ZERO_Q  = '0;
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic signed [DATA_W-1:0] word_t;
    typedef word_t [MAT_N-1:0][MAT_N-1:0] mat_t;
    typedef word_t [MAT_N-1:0] vec_t;

    // input beat
    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] entry_value;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] vec_w;
    } cmd_t;

    // result beat
    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic               saturated;
    } res_t;

    // matrix update command from the input stage
    typedef struct packed {
        logic              wr;
        logic              ident;
        logic              transpose;
        logic [1:0]        row;
        logic [1:0]        col;
        logic [DATA_W-1:0] value;
    } mat_upd_t;

    // identity within DIM, zero elsewhere
    function automatic mat_t identity_mat();
        mat_t m;
        for (int i = 0; i < MAT_N; i++)
        begin
            for (int k = 0; k < MAT_N; k++)
            begin
                m[i][k] = ((i == k) && (i < DIM)) ? ONE_Q : ZERO_Q;
            end
        end
        return m;
    endfunction

endpackage

### hdl/m4vt_matrix.sv
// m4vt_matrix: matrix store with entry write, identity load and transpose
// depends on: m4vt_pkg, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module m4vt_matrix (
    input  logic               clk,
    input  logic               rst_n,
    input  m4vt_pkg::mat_upd_t upd,
    output m4vt_pkg::mat_t     mat
);

    m4vt_pkg::mat_t mat_reg;
    m4vt_pkg::mat_t mat_next;

    // next matrix: one update per cycle at most
    always_comb
    begin
        mat_next = mat_reg;
        priority if (upd.ident)
        begin
            mat_next = m4vt_pkg::identity_mat();
        end
        else if (upd.transpose)
        begin
            for (int i = 0; i < m4vt_pkg::MAT_N; i++)
            begin
                for (int k = 0; k < m4vt_pkg::MAT_N; k++)
                begin
                    if ((i < m4vt_pkg::DIM) && (k < m4vt_pkg::DIM))
                    begin
                        mat_next[i][k] = mat_reg[k][i];
                    end
                end
            end
        end
        else if (upd.wr)
        begin
            // writes outside the active size are dropped
            if (({1'b0, upd.row} < 3'(m4vt_pkg::DIM)) && ({1'b0, upd.col} < 3'(m4vt_pkg::DIM)))
            begin
                mat_next[upd.row][upd.col] = upd.value;
            end
        end
        else
        begin
            // no update this cycle, hold the store
            mat_next = mat_reg;
        end
    end

    // store, identity out of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg <= m4vt_pkg::identity_mat();
        end
        else
        begin
            mat_reg <= mat_next;
        end
    end

    assign mat = mat_reg;

    // identity load lands on the diagonal
    `ASSERT_CLK(a_ident_diag, upd.ident |=> (mat_reg[0][0] == m4vt_pkg::ONE_Q), "identity load missed")
    // transpose moves the lower entry up
    `ASSERT_CLK(a_transpose_swap, (upd.transpose && !upd.ident) |=> (mat_reg[0][1] == $past(mat_reg[1][0])), "transpose swap wrong")

endmodule

### hdl/m4vt_dot.sv
// m4vt_dot: pipelined row-by-vector dot products with floor shift and saturation
// depends on: m4vt_pkg, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module m4vt_dot (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  m4vt_pkg::mat_t mat,
    input  m4vt_pkg::vec_t vec,
    output logic           res_valid,
    input  logic           res_ready,
    output m4vt_pkg::res_t res
);

    localparam int N = m4vt_pkg::MAT_N;
    localparam int H = m4vt_pkg::HALF_N;

    logic signed [m4vt_pkg::PROD_W-1:0] prod_reg  [N][N];
    logic signed [m4vt_pkg::PROD_W-1:0] prod_next [N][N];
    logic signed [m4vt_pkg::PAIR_W-1:0] pair_reg  [N][H];
    logic signed [m4vt_pkg::PAIR_W-1:0] pair_next [N][H];
    logic                               prod_valid_reg;
    logic                               pair_valid_reg;
    logic                               res_valid_reg;
    m4vt_pkg::res_t                     res_reg;
    m4vt_pkg::res_t                     res_next;
    logic [m4vt_pkg::DATA_W-1:0]        comp     [N];
    logic [N-1:0]                       comp_sat;

    logic res_free;
    logic pair_free;
    logic prod_free;

    // stage handshake: a stage loads when it is empty or its content moves on
    assign res_free  = !res_valid_reg || res_ready;
    assign pair_free = !pair_valid_reg || res_free;
    assign prod_free = !prod_valid_reg || pair_free;
    assign in_ready  = prod_free;

    // sixteen products, rows and columns beyond DIM contribute zero
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            for (int k = 0; k < N; k++)
            begin
                if ((i < m4vt_pkg::DIM) && (k < m4vt_pkg::DIM))
                begin
                    prod_next[i][k] = $signed(mat[i][k]) * $signed(vec[k]);
                end
                else
                begin
                    prod_next[i][k] = '0;
                end
            end
        end
    end

    // pairwise sums per row
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            for (int j = 0; j < H; j++)
            begin
                pair_next[i][j] = m4vt_pkg::PAIR_W'(prod_reg[i][2*j])
                                + m4vt_pkg::PAIR_W'(prod_reg[i][2*j+1]);
            end
        end
    end

    // row total, floor shift, clip to 32 bits
    always_comb
    begin
        logic signed [m4vt_pkg::SUM_W-1:0] sum;
        logic signed [m4vt_pkg::SUM_W-1:0] shifted;
        logic [m4vt_pkg::SUM_W-m4vt_pkg::DATA_W:0] upper;
        for (int i = 0; i < N; i++)
        begin
            sum = '0;
            for (int j = 0; j < H; j++)
            begin
                sum = sum + m4vt_pkg::SUM_W'(pair_reg[i][j]);
            end
            shifted = sum >>> m4vt_pkg::FRAC_BITS;
            upper   = shifted[m4vt_pkg::SUM_W-1:m4vt_pkg::DATA_W-1];
            if ((upper == '0) || (upper == '1))
            begin
                comp[i]     = shifted[m4vt_pkg::DATA_W-1:0];
                comp_sat[i] = 1'b0;
            end
            else
            begin
                comp[i]     = shifted[m4vt_pkg::SUM_W-1] ? m4vt_pkg::SAT_MIN : m4vt_pkg::SAT_MAX;
                comp_sat[i] = 1'b1;
            end
        end
        res_next.out_x     = comp[0];
        res_next.out_y     = comp[1];
        res_next.out_z     = comp[2];
        res_next.out_w     = comp[3];
        res_next.saturated = |comp_sat;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            pair_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_free)
            begin
                prod_valid_reg <= in_valid;
            end
            if (pair_free)
            begin
                pair_valid_reg <= prod_valid_reg;
            end
            if (res_free)
            begin
                res_valid_reg <= pair_valid_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (prod_free && in_valid)
        begin
            prod_reg <= prod_next;
        end
        if (pair_free && prod_valid_reg)
        begin
            pair_reg <= pair_next;
        end
        if (res_free && pair_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // a flagged result carries a clipped component
    `ASSERT_CLK(a_sat_value, (res_valid_reg && res_reg.saturated) |-> ((res_reg.out_x == m4vt_pkg::SAT_MAX) || (res_reg.out_x == m4vt_pkg::SAT_MIN) || (res_reg.out_y == m4vt_pkg::SAT_MAX) || (res_reg.out_y == m4vt_pkg::SAT_MIN) || (res_reg.out_z == m4vt_pkg::SAT_MAX) || (res_reg.out_z == m4vt_pkg::SAT_MIN) || (res_reg.out_w == m4vt_pkg::SAT_MAX) || (res_reg.out_w == m4vt_pkg::SAT_MIN)), "saturated flag without clipped value")
    // a full pipeline behind a stalled output takes nothing in
    `ASSERT_NEVER(a_full_stall, res_valid_reg && !res_ready && pair_valid_reg && prod_valid_reg && in_ready, "ready while pipeline full")

endmodule

### hdl/matrix4_vector_transform.sv
// Matrix-vector transform engine: 4x4 signed Q16.16 matrix times vector, one beat per clock
// unless the result side holds off. Each accepted beat enters an input register; write,
// identity and transpose beats update the matrix store from there and give no result. A
// transform beat takes sixteen parallel 32x32 products from the matrix as left by every
// earlier beat, then pairwise sums, then the row total, floor shift by the fraction width
// and saturation; it passes the input, product, pair-sum and result registers in turn. The
// rate is set by the sixteen multipliers working in parallel and by the four-stage
// pipeline, which stalls only when the result side holds off.
// depends on: m4vt_pkg, m4vt_matrix, m4vt_dot
`timescale 1ns / 1ps

module matrix4_vector_transform (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  m4vt_pkg::cmd_t cmd,
    output logic           res_valid,
    input  logic           res_ready,
    output m4vt_pkg::res_t res
);

    logic               in_valid_reg;
    m4vt_pkg::cmd_t     in_cmd_reg;
    logic               is_xform;
    logic               in_adv;
    logic               dp_ready;
    m4vt_pkg::mat_upd_t upd;
    m4vt_pkg::mat_t     mat;
    m4vt_pkg::vec_t     vec;

    // input stage: transforms wait for the datapath, others always retire
    assign is_xform  = (in_cmd_reg.op == m4vt_pkg::OP_XFORM);
    assign in_adv    = in_valid_reg && (!is_xform || dp_ready);
    assign cmd_ready = !in_valid_reg || in_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            in_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
        begin
            in_cmd_reg <= cmd;
        end
    end

    // decode matrix updates from the held beat
    always_comb
    begin
        upd           = '0;
        upd.row       = in_cmd_reg.row;
        upd.col       = in_cmd_reg.col;
        upd.value     = in_cmd_reg.entry_value;
        unique case (in_cmd_reg.op)
            m4vt_pkg::OP_WRITE:     upd.wr        = in_valid_reg;
            m4vt_pkg::OP_IDENT:     upd.ident     = in_valid_reg;
            m4vt_pkg::OP_TRANSPOSE: upd.transpose = in_valid_reg;
            m4vt_pkg::OP_XFORM:     upd.wr        = 1'b0;
            default:                upd.wr        = 1'b0;
        endcase
    end

    assign vec[0] = in_cmd_reg.vec_x;
    assign vec[1] = in_cmd_reg.vec_y;
    assign vec[2] = in_cmd_reg.vec_z;
    assign vec[3] = in_cmd_reg.vec_w;

    // matrix store
    m4vt_matrix u_matrix (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .mat   (mat)
    );

    // multiply, sum and saturate pipeline
    m4vt_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg && is_xform),
        .in_ready  (dp_ready),
        .mat       (mat),
        .vec       (vec),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

### tb/tb_matrix4_vector_transform.sv
// tb_matrix4_vector_transform: self-checking bench for the 4x4 Q16.16 matrix-vector engine
// keeps its own copy of the matrix, predicts or looks up each transform result, checks per field
// depends on: m4vt_pkg, matrix4_vector_transform
`timescale 1ns / 1ps

module tb_matrix4_vector_transform;

    import m4vt_pkg::*;

    localparam int    LIMIT_CYCLES = 400000;
    localparam int    RANDOM_BEATS = 750;
    localparam int    DRAIN_CYCLES = 10;
    localparam int    HOLD_CYCLES  = 300;
    localparam word_t QMAX         = SAT_MAX;
    localparam word_t QMIN         = SAT_MIN;
    localparam word_t QONE         = ONE_Q;

    // one row of the directed stimulus table
    typedef struct {
        cmd_t c;
        bit   typed;
        res_t exp_res;
    } plan_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    cmd_t cmd       = '0;
    logic res_ready = 1'b0;
    logic cmd_ready;
    logic res_valid;
    res_t res;

    mat_t        shadow_mat;
    res_t        xform_expect_q[$];
    plan_row_t   plan[$];
    int unsigned error_count  = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count  = 0;
    int unsigned burst_left   = 0;

    matrix4_vector_transform u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // clock and cycle count
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // mismatch report, one line each
    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        error_count++;
    endtask

    // identity within DIM
    function automatic mat_t unit_matrix();
        mat_t m;
        for (int i = 0; i < MAT_N; i++)
        begin
            for (int k = 0; k < MAT_N; k++)
            begin
                m[i][k] = (i == k && i < DIM) ? QONE : word_t'(0);
            end
        end
        return m;
    endfunction

    // matrix update for write, identity and transpose beats
    task automatic shadow_update(input cmd_t c);
        word_t t;
        case (c.op)
            OP_WRITE:
            begin
                if (c.row < DIM && c.col < DIM)
                    shadow_mat[c.row][c.col] = c.entry_value;
            end
            OP_IDENT:
            begin
                shadow_mat = unit_matrix();
            end
            OP_TRANSPOSE:
            begin
                for (int i = 0; i < DIM; i++)
                begin
                    for (int k = i + 1; k < DIM; k++)
                    begin
                        t                = shadow_mat[i][k];
                        shadow_mat[i][k] = shadow_mat[k][i];
                        shadow_mat[k][i] = t;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // exact row dot vector, floor shift, saturate
    function automatic res_t xform_predict(input mat_t m, input cmd_t c);
        word_t               v[MAT_N];
        word_t               o[MAT_N];
        word_t               a;
        word_t               b;
        logic signed [65:0]  acc;
        logic signed [65:0]  prod;
        logic                sat;
        res_t                r;
        v[0] = c.vec_x;
        v[1] = c.vec_y;
        v[2] = c.vec_z;
        v[3] = c.vec_w;
        sat  = 1'b0;
        for (int i = 0; i < MAT_N; i++)
        begin
            acc = '0;
            for (int k = 0; k < DIM; k++)
            begin
                a    = m[i][k];
                b    = v[k];
                prod = a * b;
                acc  = acc + prod;
            end
            acc = acc >>> FRAC_BITS;
            if (i >= DIM)
                o[i] = '0;
            else if (acc > 66'sh7FFFFFFF)
            begin
                o[i] = QMAX;
                sat  = 1'b1;
            end
            else if (acc < -66'sh80000000)
            begin
                o[i] = QMIN;
                sat  = 1'b1;
            end
            else
                o[i] = acc[31:0];
        end
        r.out_x     = o[0];
        r.out_y     = o[1];
        r.out_z     = o[2];
        r.out_w     = o[3];
        r.saturated = sat;
        return r;
    endfunction

    function automatic cmd_t mk_cmd(input logic [1:0] op, input logic [1:0] row,
                                    input logic [1:0] col, input word_t val, input word_t x,
                                    input word_t y, input word_t z, input word_t w);
        cmd_t c;
        c.op          = op;
        c.row         = row;
        c.col         = col;
        c.entry_value = val;
        c.vec_x       = x;
        c.vec_y       = y;
        c.vec_z       = z;
        c.vec_w       = w;
        return c;
    endfunction

    function automatic res_t mk_res(input word_t x, input word_t y, input word_t z,
                                    input word_t w, input logic s);
        res_t r;
        r.out_x     = x;
        r.out_y     = y;
        r.out_z     = z;
        r.out_w     = w;
        r.saturated = s;
        return r;
    endfunction

    task automatic add_row(input cmd_t c, input bit typed, input res_t e);
        plan_row_t p;
        p.c       = c;
        p.typed   = typed;
        p.exp_res = e;
        plan.push_back(p);
    endtask

    // mostly small Q16.16 values, some full range, some extremes
    function automatic word_t rand_word();
        word_t w;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: w = $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
            5, 6, 7:       w = $urandom;
            8:
            begin
                case ($urandom_range(0, 5))
                    0:       w = QMAX;
                    1:       w = QMIN;
                    2:       w = QONE;
                    3:       w = -QONE;
                    4:       w = -1;
                    default: w = 0;
                endcase
            end
            default:       w = $signed($urandom_range(0, 32)) - 16;
        endcase
        return w;
    endfunction

    function automatic cmd_t rand_cmd(input logic [1:0] op);
        cmd_t c;
        c       = mk_cmd(op, 2'($urandom), 2'($urandom), rand_word(), rand_word(),
                         rand_word(), rand_word(), rand_word());
        return c;
    endfunction

    // offer one beat, hold it until taken, then update the mirror or queue the expected result
    task automatic send_beat(input cmd_t c, input bit typed, input res_t typed_res);
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        if (c.op == OP_XFORM)
            xform_expect_q.push_back(typed ? typed_res : xform_predict(shadow_mat, c));
        else
            shadow_update(c);
        @(negedge clk);
    endtask

    // bursts of random length with random gaps between them
    task automatic pace();
        int unsigned gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // result check against the oldest pending transform
    always @(posedge clk)
    begin : result_check
        res_t  want;
        word_t got_w[4];
        word_t want_w[4];
        if (rst_n && res_valid && res_ready)
        begin
            results_seen++;
            if (xform_expect_q.size() == 0)
                report_mismatch("result beat with no transform pending");
            else
            begin
                want      = xform_expect_q.pop_front();
                got_w     = '{res.out_x, res.out_y, res.out_z, res.out_w};
                want_w    = '{want.out_x, want.out_y, want.out_z, want.out_w};
                for (int i = 0; i < 4; i++)
                begin
                    if (got_w[i] !== want_w[i])
                        report_mismatch($sformatf("result %0d lane %0d: got %h want %h",
                                                  results_seen, i, got_w[i], want_w[i]));
                end
                if (res.saturated !== want.saturated)
                    report_mismatch($sformatf("result %0d saturated: got %b want %b",
                                              results_seen, res.saturated, want.saturated));
            end
        end
    end

    // receiver: a stall pattern that is redrawn periodically, plus one long hold-off
    initial
    begin : rx_side
        int unsigned tick;
        int unsigned hold_left;
        bit          hold_done;
        bit [7:0]    pat;
        tick      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        pat       = '1;
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= 60)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (tick % 64 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       pat = '1;
                    1:       pat = 8'($urandom);
                    2:       pat = ~(8'd1 << $urandom_range(0, 7));
                    default: pat = 8'($urandom) & 8'($urandom);
                endcase
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else
                res_ready <= pat[tick % 8];
            tick++;
        end
    end

    // run limit
    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("matrix4_vector_transform verification failed");
        $finish;
    end

    // main sequence
    initial
    begin : main_seq
        cmd_t        grp[$];
        cmd_t        c;
        int unsigned sent;
        int unsigned pick;

        // directed table
        add_row(mk_cmd(OP_XFORM, 2'd0, 2'd0, 0, QONE, 2 * QONE, 3 * QONE, -4 * QONE), 1'b1,
                mk_res(QONE, 2 * QONE, 3 * QONE, -4 * QONE, 1'b0));
        add_row(mk_cmd(OP_XFORM, 2'd3, 2'd3, QMIN, QMAX, QMIN, -1, 0), 1'b1,
                mk_res(QMAX, QMIN, -1, 0, 1'b0));
        add_row(mk_cmd(OP_WRITE, 2'd0, 2'd0, QMAX, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_cmd(OP_WRITE, 2'd0, 2'd1, QMAX, -1, -1, -1, -1), 1'b0, '0);
        add_row(mk_cmd(OP_XFORM, 2'd0, 2'd0, 0, QMAX, QMAX, 0, 0), 1'b1,
                mk_res(QMAX, QMAX, 0, 0, 1'b1));
        add_row(mk_cmd(OP_XFORM, 2'd0, 2'd0, 0, QMIN, QMIN, 0, 0), 1'b1,
                mk_res(QMIN, QMIN, 0, 0, 1'b1));
        add_row(mk_cmd(OP_TRANSPOSE, 2'd3, 2'd2, -1, QMAX, QMIN, -1, 1), 1'b0, '0);
        add_row(mk_cmd(OP_XFORM, 2'd0, 2'd0, 0, QONE, QONE, QONE, QONE), 1'b0, '0);
        add_row(mk_cmd(OP_TRANSPOSE, 2'd0, 2'd0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_cmd(OP_XFORM, 2'd1, 2'd2, QMAX, QONE, QONE, QONE, QONE), 1'b0, '0);
        add_row(mk_cmd(OP_IDENT, 2'd3, 2'd3, QMIN, QMAX, QMAX, QMAX, QMAX), 1'b0, '0);
        add_row(mk_cmd(OP_WRITE, 2'd3, 2'd3, QMIN, -1, -1, -1, -1), 1'b0, '0);
        add_row(mk_cmd(OP_WRITE, 2'd1, 2'd1, 1, 0, 0, 0, 0), 1'b0, '0);
        // negative product truncates toward minus infinity, square of the minimum clips
        add_row(mk_cmd(OP_XFORM, 2'd2, 2'd1, -1, 0, -1, 0, QMIN), 1'b1,
                mk_res(0, -1, 0, QMAX, 1'b1));
        add_row(mk_cmd(OP_XFORM, 2'd0, 2'd0, 0, 0, 1, 0, 0), 1'b1,
                mk_res(0, 0, 0, 0, 1'b0));
        add_row(mk_cmd(OP_WRITE, 2'd2, 2'd3, -QONE, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_cmd(OP_WRITE, 2'd3, 2'd0, QMAX, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_cmd(OP_WRITE, 2'd0, 2'd3, QMIN, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_cmd(OP_XFORM, 2'd3, 2'd3, -1, QMAX, QMIN, QMAX, QMIN), 1'b0, '0);
        add_row(mk_cmd(OP_IDENT, 2'd0, 2'd0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_cmd(OP_XFORM, 2'd0, 2'd0, 0, -QONE, 0, 0, 0), 1'b1,
                mk_res(-QONE, 0, 0, 0, 1'b0));

        // reset
        shadow_mat = unit_matrix();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            send_beat(plan[i].c, plan[i].typed, plan[i].exp_res);
            pace();
        end

        // random part: single beats, full matrix loads, transpose and identity runs
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            grp = {};
            case ($urandom_range(0, 9))
                7:
                begin
                    for (int r = 0; r < MAT_N; r++)
                    begin
                        for (int k = 0; k < MAT_N; k++)
                        begin
                            c     = rand_cmd(OP_WRITE);
                            c.row = 2'(r);
                            c.col = 2'(k);
                            grp.push_back(c);
                        end
                    end
                    repeat ($urandom_range(1, 4)) grp.push_back(rand_cmd(OP_XFORM));
                end
                8:
                begin
                    grp.push_back(rand_cmd(OP_TRANSPOSE));
                    repeat ($urandom_range(1, 3)) grp.push_back(rand_cmd(OP_XFORM));
                end
                9:
                begin
                    grp.push_back(rand_cmd(OP_IDENT));
                    repeat ($urandom_range(0, 3)) grp.push_back(rand_cmd(OP_WRITE));
                    repeat ($urandom_range(1, 3)) grp.push_back(rand_cmd(OP_XFORM));
                end
                default:
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40)
                        grp.push_back(rand_cmd(OP_WRITE));
                    else if (pick < 85)
                        grp.push_back(rand_cmd(OP_XFORM));
                    else if (pick < 92)
                        grp.push_back(rand_cmd(OP_IDENT));
                    else
                        grp.push_back(rand_cmd(OP_TRANSPOSE));
                end
            endcase
            foreach (grp[j])
            begin
                send_beat(grp[j], 1'b0, '0);
                pace();
                sent++;
            end
        end
        cmd_valid <= 1'b0;

        // drain
        while (xform_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("matrix4_vector_transform verification clean");
        else
            $display("matrix4_vector_transform verification failed");
        $finish;
    end

endmodule
